@@ design/plm_pkg.sv @@
// package for the positional list store: action codes, status codes, field widths
// no dependencies; used by the top level and the port checker
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_END   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_LAST  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_AT    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DUMP      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

`default_nettype wire

@@ design/positional_list_store.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in one synchronous ram
// (index 0 is the front). An action needs no further states when it ends in a
// status result or touches only the count or the end of the list: insert at the
// end, delete last, and all error cases. An insert in front of entry t and a
// delete at entry t that has entries behind it take longer, since these move
// one ram word a cycle through the one read port and the one write port. After
// the first read, a dump streams one entry a cycle, slower if the output is
// stalled. The status of a change is sent at the transfer of the item, before
// the entries have finished moving; the next item waits until they have.
// top level; depends on plm_pkg and plm_ram
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [2:0]         i_action,
    input  wire  signed [31:0] i_item_value,
    input  wire  [4:0]         i_position,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_out_value,
    output logic [1:0]         o_status,
    output logic               o_last_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > plm_pkg::POS_W) ? CW : plm_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_DUMP
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_idx, n_idx;
    logic [AW-1:0]                 r_tgt, n_tgt;
    logic [plm_pkg::VALUE_W-1:0]   r_val, n_val;
    logic                          r_out_valid, n_out_valid;
    logic [plm_pkg::VALUE_W-1:0]   r_out_value, n_out_value;
    logic [plm_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                          r_out_last, n_out_last;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [plm_pkg::VALUE_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [plm_pkg::VALUE_W-1:0]   ram_rdata;

    logic                          can_out;
    logic                          full;
    logic                          empty;
    logic [PW-1:0]                 pos_ext;
    logic                          pos_ok;
    logic [AW-1:0]                 pos_idx;
    logic [AW-1:0]                 cnt_m1;
    logic                          st_emit;
    logic [plm_pkg::STATUS_W-1:0]  st_code;
    logic                          ins_go;
    logic                          ins_at_end;
    logic [AW-1:0]                 ins_idx;

    plm_ram #(
        .WIDTH (plm_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign can_out = !r_out_valid || !i_stall;
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign pos_ext = PW'(i_position);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= PW'(r_count));
    assign pos_idx = AW'(pos_ext - PW'(1));
    assign cnt_m1  = AW'(r_count - CW'(1));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_val        = r_val;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        st_emit      = 1'b0;
        st_code      = plm_pkg::ST_OK;
        ins_go       = 1'b0;
        ins_at_end   = 1'b0;
        ins_idx      = '0;
        o_stall      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_stall = !can_out;
                if (i_valid && can_out) begin
                    unique case (i_action)
                        plm_pkg::ACT_INS_FRONT: begin
                            if (full) begin
                                st_emit = 1'b1;
                                st_code = plm_pkg::ST_FULL;
                            end else begin
                                ins_go     = 1'b1;
                                ins_idx    = '0;
                                ins_at_end = empty;
                            end
                        end
                        plm_pkg::ACT_INS_END: begin
                            if (full) begin
                                st_emit = 1'b1;
                                st_code = plm_pkg::ST_FULL;
                            end else begin
                                ins_go     = 1'b1;
                                ins_idx    = AW'(r_count);
                                ins_at_end = 1'b1;
                            end
                        end
                        plm_pkg::ACT_INS_AT: begin
                            if (!pos_ok) begin
                                st_emit = 1'b1;
                                st_code = plm_pkg::ST_RANGE;
                            end else if (full) begin
                                st_emit = 1'b1;
                                st_code = plm_pkg::ST_FULL;
                            end else begin
                                ins_go  = 1'b1;
                                ins_idx = pos_idx;
                            end
                        end
                        plm_pkg::ACT_DEL_LAST: begin
                            st_emit = 1'b1;
                            if (empty) begin
                                st_code = plm_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        plm_pkg::ACT_DEL_AT: begin
                            st_emit = 1'b1;
                            if (empty) begin
                                st_code = plm_pkg::ST_EMPTY;
                            end else if (!pos_ok) begin
                                st_code = plm_pkg::ST_RANGE;
                            end else begin
                                n_count = r_count - CW'(1);
                                // removing the tail needs no move
                                if (pos_idx != cnt_m1) begin
                                    ram_re    = 1'b1;
                                    ram_raddr = AW'(pos_idx + AW'(1));
                                    n_idx     = AW'(pos_idx + AW'(1));
                                    n_tgt     = cnt_m1;
                                    n_state   = S_SHIFT_DN;
                                end
                            end
                        end
                        plm_pkg::ACT_DUMP: begin
                            if (empty) begin
                                st_emit = 1'b1;
                                st_code = plm_pkg::ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_tgt     = cnt_m1;
                                n_state   = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (ins_go) begin
                        st_emit = 1'b1;
                        n_count = r_count + CW'(1);
                        if (ins_at_end) begin
                            ram_we    = 1'b1;
                            ram_waddr = ins_idx;
                            ram_wdata = i_item_value;
                        end else begin
                            // move entries up starting at the tail
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m1;
                            n_idx     = cnt_m1;
                            n_tgt     = ins_idx;
                            n_val     = i_item_value;
                            n_state   = S_SHIFT_UP;
                        end
                    end

                    if (st_emit) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_status = st_code;
                        n_out_last   = 1'b1;
                    end
                end
            end
            S_SHIFT_UP: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx + AW'(1));
                ram_wdata = ram_rdata;
                if (r_idx == r_tgt) begin
                    n_state = S_PLACE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx - AW'(1));
                    n_idx     = AW'(r_idx - AW'(1));
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_tgt;
                ram_wdata = r_val;
                n_state   = S_IDLE;
            end
            S_SHIFT_DN: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx - AW'(1));
                ram_wdata = ram_rdata;
                if (r_idx == r_tgt) begin
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + AW'(1));
                    n_idx     = AW'(r_idx + AW'(1));
                end
            end
            S_DUMP: begin
                // read data holds until it is moved into the output register
                if (can_out) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = ram_rdata;
                    n_out_status = plm_pkg::ST_OK;
                    n_out_last   = (r_idx == r_tgt);
                    if (r_idx == r_tgt) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(r_idx + AW'(1));
                        n_idx     = AW'(r_idx + AW'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_tgt        <= n_tgt;
        r_val        <= n_val;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_out_value   = $signed(r_out_value);
    assign o_status      = r_out_status;
    assign o_last_result = r_out_last;

endmodule

`default_nettype wire

@@ design/plm_ram.sv @@
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies; old data is returned on a read of the entry being written
`timescale 1ns / 1ps
`default_nettype none

module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                                      i_clk,
    input  wire                                      i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                         i_wdata,
    input  wire                                      i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/plm_checker.sv @@
// port-level checker for the positional list store, bound to the top level
// depends on plm_pkg
`timescale 1ns / 1ps
`default_nettype none

module plm_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire [2:0]         i_action,
    input wire signed [31:0] i_item_value,
    input wire [4:0]         i_position,
    input wire               o_valid,
    input wire               i_stall,
    input wire signed [31:0] o_out_value,
    input wire [1:0]         o_status,
    input wire               o_last_result
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value) && $stable(o_status)
            && $stable(o_last_result))
        else $error("output changed while stalled");

    // an error status is a lone result carrying zero
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != plm_pkg::ST_OK) |-> (o_out_value == 0) && o_last_result)
        else $error("error status with data or without last mark");

    // every change action answers in the cycle after its transfer
    a_change_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == plm_pkg::ACT_INS_FRONT
            || i_action == plm_pkg::ACT_INS_END || i_action == plm_pkg::ACT_INS_AT
            || i_action == plm_pkg::ACT_DEL_LAST || i_action == plm_pkg::ACT_DEL_AT)
        |=> o_valid && o_last_result && (o_out_value == 0))
        else $error("change action without its status result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

endmodule

bind positional_list_store plm_checker u_plm_checker (.*);

`default_nettype wire
